@@ design/sieve_prime_counter_top_macros.svh @@
// Assertion macros used by the sieve prime counter RTL
`ifndef SIEVE_PRIME_COUNTER_TOP_MACROS_SVH
`define SIEVE_PRIME_COUNTER_TOP_MACROS_SVH

// implication checked in the same cycle, sampled on clk, off during reset
`define SPC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the following cycle
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/spc_pkg.sv @@
// Shared constants and controller/datapath interface types for the sieve prime counter
package spc_pkg;

	localparam int QUERY_W        = 17;
	localparam int LIMIT_W        = 17;
	localparam int COUNT_W        = 13;
	localparam int S_TDATA_W      = 24;
	localparam int M_TDATA_W      = 16;
	localparam int MAX_NUMBER_DEF = 65536;
	localparam int FIRST_PRIME    = 2;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic load_query;
		logic latch_lim;
		logic n_clear;
		logic n_two;
		logic n_inc;
		logic fill_wr;
		logic rd_n;
		logic rd_port;
		logic rd_q;
		logic count_wr;
		logic count_inc;
		logic m_init;
		logic cross_wr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic n_eq_lim;
		logic flag_rd;
		logic m_le_lim;
		logic out_free;
	} sts_t;

endpackage

@@ design/spc_ctrl.sv @@
// Controller state machine: sieve build sequence and query handshake
module spc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  spc_pkg::sts_t sts,
	output spc_pkg::cmd_t cmd
);
	import spc_pkg::*;

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_FILL   = 8'b0000_0010,
		ST_SRD    = 8'b0000_0100,
		ST_SCHK   = 8'b0000_1000,
		ST_CROSS  = 8'b0001_0000,
		ST_LOOKUP = 8'b0010_0000,
		ST_RESP   = 8'b0100_0000,
		ST_READY  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) || (state_q == ST_READY);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.load_query = 1'b1;
					cmd.latch_lim  = 1'b1;
					cmd.n_clear    = 1'b1;
					state_d        = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_wr = 1'b1;
				if (sts.n_eq_lim) begin
					cmd.n_two = 1'b1;
					state_d   = ST_SRD;
				end else begin
					cmd.n_inc = 1'b1;
				end
			end
			ST_SRD: begin
				cmd.rd_n = 1'b1;
				state_d  = ST_SCHK;
			end
			ST_SCHK: begin
				cmd.count_wr = 1'b1;
				if (sts.flag_rd) begin
					cmd.count_inc = 1'b1;
					cmd.m_init    = 1'b1;
					state_d       = ST_CROSS;
				end else if (sts.n_eq_lim) begin
					state_d = ST_LOOKUP;
				end else begin
					cmd.n_inc = 1'b1;
					state_d   = ST_SRD;
				end
			end
			ST_CROSS: begin
				if (sts.m_le_lim) begin
					cmd.cross_wr = 1'b1;
				end else if (sts.n_eq_lim) begin
					state_d = ST_LOOKUP;
				end else begin
					cmd.n_inc = 1'b1;
					state_d   = ST_SRD;
				end
			end
			ST_LOOKUP: begin
				cmd.rd_q = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_READY;
				end
			end
			ST_READY: begin
				if (accept) begin
					cmd.rd_port = 1'b1;
					state_d     = ST_RESP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ design/spc_datapath.sv @@
// Datapath: limit register, sieve and count memories, counters, output register
`include "sieve_prime_counter_top_macros.svh"

module spc_datapath #(
	parameter int MAX_NUMBER = spc_pkg::MAX_NUMBER_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sieve_limit_wr_en,
	input  logic [spc_pkg::LIMIT_W-1:0]     sieve_limit_wr_data,
	input  logic [spc_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [spc_pkg::M_TDATA_W-1:0]   m_tdata,
	input  spc_pkg::cmd_t                   cmd,
	output spc_pkg::sts_t                   sts
);
	import spc_pkg::*;

	localparam int AW    = $clog2(MAX_NUMBER + 1);
	localparam int CMPW  = (AW > LIMIT_W) ? AW : LIMIT_W;
	localparam int DEPTH = MAX_NUMBER + 1;

	logic                flags_mem [DEPTH];
	logic [COUNT_W-1:0]  count_mem [DEPTH];

	logic [CMPW-1:0]     sieve_limit_q;
	logic [AW-1:0]       lim_q;
	logic [AW-1:0]       lim_eff;
	logic [QUERY_W-1:0]  query_q;
	logic [AW-1:0]       n_q;
	logic [AW:0]         m_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [COUNT_W-1:0]  cnt_nxt;

	logic [QUERY_W-1:0]  q_sel;
	logic [CMPW-1:0]     q_ext;
	logic                q_oor;
	logic [AW-1:0]       q_addr;
	logic [AW-1:0]       rd_addr;
	logic                rd_en;

	logic                flag_rd_s1;
	logic [COUNT_W-1:0]  count_rd_s1;
	logic                oor_s1;

	logic                m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	logic                flag_we;
	logic [AW-1:0]       flag_waddr;
	logic                flag_wdata;
	logic                count_we;
	logic [COUNT_W-1:0]  count_wdata;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sieve_limit_q <= CMPW'(MAX_NUMBER);
		end else if (sieve_limit_wr_en) begin
			sieve_limit_q <= CMPW'(sieve_limit_wr_data);
		end
	end

	always_comb begin
		priority if (sieve_limit_q < CMPW'(FIRST_PRIME)) begin
			lim_eff = AW'(FIRST_PRIME);
		end else if (sieve_limit_q > CMPW'(MAX_NUMBER)) begin
			lim_eff = AW'(MAX_NUMBER);
		end else begin
			lim_eff = sieve_limit_q[AW-1:0];
		end
	end

	// build counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= '0;
			n_q   <= '0;
			m_q   <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.latch_lim) begin
				lim_q <= lim_eff;
				cnt_q <= '0;
			end else if (cmd.count_wr) begin
				cnt_q <= cnt_nxt;
			end
			priority if (cmd.n_clear) begin
				n_q <= '0;
			end else if (cmd.n_two) begin
				n_q <= AW'(FIRST_PRIME);
			end else if (cmd.n_inc) begin
				n_q <= n_q + AW'(1);
			end
			if (cmd.m_init) begin
				m_q <= {n_q, 1'b0};
			end else if (cmd.cross_wr) begin
				m_q <= m_q + {1'b0, n_q};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			query_q <= s_tdata[QUERY_W-1:0];
		end
	end

	assign cnt_nxt = (cmd.count_inc && (cnt_q != COUNT_MAX)) ? cnt_q + COUNT_W'(1) : cnt_q;

	// query address clamp
	assign q_sel  = cmd.rd_port ? s_tdata[QUERY_W-1:0] : query_q;
	assign q_ext  = CMPW'(q_sel);
	assign q_oor  = q_ext > CMPW'(lim_q);
	assign q_addr = q_oor ? lim_q : q_ext[AW-1:0];

	assign rd_en   = cmd.rd_n || cmd.rd_port || cmd.rd_q;
	assign rd_addr = cmd.rd_n ? n_q : q_addr;

	// memory write ports
	assign flag_we     = cmd.fill_wr || cmd.cross_wr;
	assign flag_waddr  = cmd.cross_wr ? m_q[AW-1:0] : n_q;
	assign flag_wdata  = cmd.fill_wr && (n_q >= AW'(FIRST_PRIME));
	assign count_we    = cmd.fill_wr || cmd.count_wr;
	assign count_wdata = cmd.count_wr ? cnt_nxt : '0;

	always_ff @(posedge clk) begin
		if (flag_we) begin
			flags_mem[flag_waddr] <= flag_wdata;
		end
		if (count_we) begin
			count_mem[n_q] <= count_wdata;
		end
		if (rd_en) begin
			flag_rd_s1  <= flags_mem[rd_addr];
			count_rd_s1 <= count_mem[rd_addr];
			oor_s1      <= q_oor && !cmd.rd_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_tdata_q <= M_TDATA_W'({oor_s1, flag_rd_s1, count_rd_s1});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign sts.n_eq_lim = (n_q == lim_q);
	assign sts.flag_rd  = flag_rd_s1;
	assign sts.m_le_lim = (m_q <= {1'b0, lim_q});
	assign sts.out_free = !m_tvalid_q || m_tready;

	`SPC_ASSERT_SAME(a_cross_in_range, cmd.cross_wr, m_q <= {1'b0, lim_q}, "cross-off past limit")
	`SPC_ASSERT_SAME(a_load_out_free, cmd.load_out, !m_tvalid_q || m_tready, "result overwritten")
	`SPC_ASSERT_SAME(a_lookup_addr, cmd.rd_port || cmd.rd_q, q_addr <= lim_q, "lookup past limit")
	`SPC_ASSERT_NEXT(a_count_mono, cmd.count_wr, cnt_q >= $past(cnt_q), "prime count decreased")

endmodule

@@ design/sieve_prime_counter_top.sv @@
// Top level of the sieve prime counter: controller plus datapath
// Usage:
//   Queries enter on the s_ stream (17-bit number in s_tdata), answers leave on the m_ stream.
//   Each query yields exactly one word: prime count up to the number, prime flag and an
//   out-of-range flag (query above the limit is answered at the limit).
//   sieve_limit_wr_en/sieve_limit_wr_data set the limit; write it only while idle.
//   The limit is latched by the first query after reset; later writes have no effect, as
//   reset restores the limit register to MAX_NUMBER.
// Build and query sequence:
//   First query: the sieve is built before the answer. Fill writes every entry from 0 to L,
//   then each number from 2 up is read and checked; each prime crosses off its multiples
//   one by one before leaving its loop, and the lookup follows. L is the clamped limit.
//   After the build a query reads the table and its answer is then loaded into the output
//   register; the controller accepts a new query only once that answer is loaded.
// Reset: arst_n clears the controller and output valid; the tables keep no valid state
//   and are rebuilt on the next first query.
// Stall: the result sits in the output register; s_tready stays low while a fresh
//   result is waiting behind a held output word.
module sieve_prime_counter_top #(
	parameter int MAX_NUMBER = spc_pkg::MAX_NUMBER_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sieve_limit_wr_en,
	input  logic [spc_pkg::LIMIT_W-1:0]   sieve_limit_wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [spc_pkg::S_TDATA_W-1:0] s_tdata,   // [16:0] query_number
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [spc_pkg::M_TDATA_W-1:0] m_tdata    // [12:0] prime_count, [13] is_prime,
	                                                 // [14] out_of_range
);
	import spc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	spc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	spc_datapath #(
		.MAX_NUMBER (MAX_NUMBER)
	) u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.sieve_limit_wr_en   (sieve_limit_wr_en),
		.sieve_limit_wr_data (sieve_limit_wr_data),
		.s_tdata             (s_tdata),
		.m_tvalid            (m_tvalid),
		.m_tready            (m_tready),
		.m_tdata             (m_tdata),
		.cmd                 (cmd),
		.sts                 (sts)
	);

endmodule
